// ----- hw/rtl/button_encoder_event_generator_top_assert.svh -----
// Assertion macros used by button_encoder_event_generator_top.
`ifndef BUTTON_ENCODER_EVENT_GENERATOR_TOP_ASSERT_SVH
`define BUTTON_ENCODER_EVENT_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BEG_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BEG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/btn_enc_pkg.sv -----
// ----------------------------------------------------------------------------
// btn_enc_pkg
// Constants shared by the button and encoder event generator.
// ----------------------------------------------------------------------------
package btn_enc_pkg;

    localparam int NUM_BUTTONS = 3;
    localparam int LEVEL_W     = 3;
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_DT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_ON_DOWN = 2'd3;

    // Reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd30;
    localparam logic [15:0] HOLD_RST     = 16'd800;
    localparam logic [4:0]  CPD_RST      = 5'd4;
    localparam logic [2:0]  MASK_RST     = 3'd2;

    // Event codes
    localparam logic [3:0] EV_NONE = 4'd0;
    localparam logic [3:0] EV_CW   = 4'd1;
    localparam logic [3:0] EV_CCW  = 4'd2;
    localparam int         EV_PRESS_BASE = 3;

    localparam int DIV_STEPS = 32;

endpackage

// ----- hw/rtl/button_encoder_event_generator_top.sv -----
// ----------------------------------------------------------------------------
// button_encoder_event_generator_top
// Debounced button press/hold events and quadrature encoder detents.
// ----------------------------------------------------------------------------
// Each poll transfer yields exactly one event code. After acceptance the
// sequencer forms the count delta and its magnitude, a radix-2 restoring
// divider reuses one 6-bit subtract for every quotient bit to split the
// remainder into whole detents, the apply step merges them into the
// saturating pending count, the scan runs the debounce and press/hold logic
// one button at a time, and the last steps pick a detent and load the output
// register. The scan stops at the first button that reports, and the detent
// step is then skipped. The load waits while the previous result is still
// held for the sink. The input side is ready again once the result is loaded,
// while that result still waits for the sink.
module button_encoder_event_generator_top
    import btn_enc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // poll input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_now_ms,
    input  logic [LEVEL_W-1:0]    s_button_levels,
    input  logic signed [31:0]    s_encoder_count,
    // event output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_event_code,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DELTA = 3'd1;
    localparam logic [2:0] ST_ABS   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_APPLY = 3'd4;
    localparam logic [2:0] ST_BTN   = 3'd5;
    localparam logic [2:0] ST_DET   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [15:0] debounce_reg, hold_reg;
    logic [4:0]  cpd_reg;
    logic [2:0]  mask_reg;
    logic [4:0]  size_eff;

    // captured poll
    logic [31:0]         now_reg;
    logic [LEVEL_W-1:0]  levels_reg;
    logic [31:0]         count_reg;

    // encoder state
    logic [31:0]        prev_reg, prev_next;
    logic [31:0]        sub_reg, sub_next;
    logic signed [15:0] pend_reg, pend_next;
    logic [31:0]        sub_mag;

    // divider
    logic [31:0] dvd_reg, dvd_next;
    logic [4:0]  rem_reg, rem_next;
    logic        neg_reg, neg_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic [5:0]  trial;

    // button state
    logic [NUM_BUTTONS-1:0] last_reg, last_next;
    logic [NUM_BUTTONS-1:0] armed_reg, armed_next;
    logic [NUM_BUTTONS-1:0] sp_reg, sp_next;
    logic [NUM_BUTTONS-1:0] hd_reg, hd_next;
    logic [31:0] change_reg [NUM_BUTTONS];
    logic [31:0] change_next [NUM_BUTTONS];
    logic [31:0] down_reg [NUM_BUTTONS];
    logic [31:0] down_next [NUM_BUTTONS];
    logic [BTN_IDX_W-1:0] btn_idx_reg, btn_idx_next;

    // result
    logic [3:0] ev_reg, ev_next;
    logic [3:0] out_reg, out_next;
    logic       m_valid_reg, m_valid_next;

    // button step signals
    logic        b_lvl, b_on_down, b_low;
    logic [31:0] b_since_change, b_since_down;
    logic [3:0]  b_press, b_code;
    logic        b_last_btn;

    // encoder apply signals
    logic signed [32:0] whole;
    logic signed [33:0] pend_sum;
    logic [31:0]        rem_signed;

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_event_code = out_reg;

    always_comb begin
        if (cpd_reg == 5'd0) begin
            size_eff = 5'd1;
        end else if (cpd_reg > 5'd16) begin
            size_eff = 5'd16;
        end else begin
            size_eff = cpd_reg;
        end
    end

    assign sub_mag = sub_reg[31] ? (32'd0 - sub_reg) : sub_reg;
    assign trial   = {rem_reg, dvd_reg[31]} - {1'b0, size_eff};

    assign whole      = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign pend_sum   = 34'(pend_reg) + 34'(whole);
    assign rem_signed = neg_reg ? (32'd0 - {27'd0, rem_reg}) : {27'd0, rem_reg};

    // per-button view at the scan index
    always_comb begin
        b_lvl = 1'b0;
        b_on_down = 1'b0;
        if (int'(btn_idx_reg) < LEVEL_W) begin
            b_lvl     = levels_reg[btn_idx_reg];
            b_on_down = mask_reg[btn_idx_reg];
        end
        b_low          = !b_lvl;
        b_since_change = now_reg - change_reg[btn_idx_reg];
        b_since_down   = now_reg - down_reg[btn_idx_reg];
        b_press        = 4'(EV_PRESS_BASE + 2 * int'(btn_idx_reg));
        b_last_btn     = (int'(btn_idx_reg) == NUM_BUTTONS - 1);
    end

    always_comb begin
        state_next   = state_reg;
        prev_next    = prev_reg;
        sub_next     = sub_reg;
        pend_next    = pend_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        div_cnt_next = div_cnt_reg;
        last_next    = last_reg;
        armed_next   = armed_reg;
        sp_next      = sp_reg;
        hd_next      = hd_reg;
        change_next  = change_reg;
        down_next    = down_reg;
        btn_idx_next = btn_idx_reg;
        ev_next      = ev_reg;
        out_next     = out_reg;
        b_code       = EV_NONE;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA: begin
                sub_next   = sub_reg + (count_reg - prev_reg);
                prev_next  = count_reg;
                state_next = ST_ABS;
            end
            ST_ABS: begin
                dvd_next     = sub_mag;
                neg_next     = sub_reg[31];
                rem_next     = 5'd0;
                div_cnt_next = 5'd0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                // one quotient bit per cycle
                if (!trial[5]) begin
                    rem_next = trial[4:0];
                    dvd_next = {dvd_reg[30:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[3:0], dvd_reg[31]};
                    dvd_next = {dvd_reg[30:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (int'(div_cnt_reg) == DIV_STEPS - 1) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (dvd_reg != 32'd0) begin
                    sub_next = rem_signed;
                    if (pend_sum > 34'sd32767) begin
                        pend_next = 16'sh7fff;
                    end else if (pend_sum < -34'sd32768) begin
                        pend_next = -16'sh8000;
                    end else begin
                        pend_next = pend_sum[15:0];
                    end
                end
                btn_idx_next = '0;
                state_next   = ST_BTN;
            end
            ST_BTN: begin
                priority if (b_lvl != last_reg[btn_idx_reg]) begin
                    last_next[btn_idx_reg]   = b_lvl;
                    change_next[btn_idx_reg] = now_reg;
                end else if (b_since_change < {16'd0, debounce_reg}) begin
                    b_code = EV_NONE;
                end else if (!armed_reg[btn_idx_reg]) begin
                    if (!b_low) begin
                        armed_next[btn_idx_reg] = 1'b1;
                    end
                end else if (b_low && !sp_reg[btn_idx_reg]) begin
                    sp_next[btn_idx_reg]   = 1'b1;
                    down_next[btn_idx_reg] = now_reg;
                    hd_next[btn_idx_reg]   = b_on_down;
                    b_code = b_on_down ? b_press : EV_NONE;
                end else if (b_low && !hd_reg[btn_idx_reg]
                             && b_since_down >= {16'd0, hold_reg}) begin
                    hd_next[btn_idx_reg] = 1'b1;
                    b_code = b_press + 4'd1;
                end else if (!b_low && sp_reg[btn_idx_reg]) begin
                    sp_next[btn_idx_reg] = 1'b0;
                    b_code = hd_reg[btn_idx_reg] ? EV_NONE : b_press;
                end else begin
                    b_code = EV_NONE;
                end
                // first reporting button wins; later ones stay untouched
                if (b_code != EV_NONE) begin
                    ev_next    = b_code;
                    state_next = ST_OUT;
                end else if (b_last_btn) begin
                    state_next = ST_DET;
                end else begin
                    btn_idx_next = btn_idx_reg + BTN_IDX_W'(1);
                end
            end
            ST_DET: begin
                if (pend_reg > 16'sd0) begin
                    pend_next = pend_reg - 16'sd1;
                    ev_next   = EV_CW;
                end else if (pend_reg < 16'sd0) begin
                    pend_next = pend_reg + 16'sd1;
                    ev_next   = EV_CCW;
                end else begin
                    ev_next   = EV_NONE;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next     = ev_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            debounce_reg <= DEBOUNCE_RST;
            hold_reg     <= HOLD_RST;
            cpd_reg      <= CPD_RST;
            mask_reg     <= MASK_RST;
            prev_reg     <= '0;
            sub_reg      <= '0;
            pend_reg     <= '0;
            last_reg     <= '1;
            armed_reg    <= '0;
            sp_reg       <= '0;
            hd_reg       <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                change_reg[i] <= '0;
                down_reg[i]   <= '0;
            end
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            sub_reg     <= sub_next;
            pend_reg    <= pend_next;
            last_reg    <= last_next;
            armed_reg   <= armed_next;
            sp_reg      <= sp_next;
            hd_reg      <= hd_next;
            change_reg  <= change_next;
            down_reg    <= down_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_DEBOUNCE:      debounce_reg <= cfg_data;
                    REG_HOLD_MS:       hold_reg     <= cfg_data;
                    REG_COUNTS_PER_DT: cpd_reg      <= cfg_data[4:0];
                    REG_PRESS_ON_DOWN: mask_reg     <= cfg_data[2:0];
                    default:           cpd_reg      <= cpd_reg;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg    <= s_now_ms;
            levels_reg <= s_button_levels;
            count_reg  <= s_encoder_count;
        end
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        div_cnt_reg <= div_cnt_next;
        btn_idx_reg <= btn_idx_next;
        ev_reg      <= ev_next;
        out_reg     <= out_next;
    end

`include "button_encoder_event_generator_top_assert.svh"

    `BEG_ASSERT_IMPL(a_rem_below_size, aclk, aresetn, state_reg == ST_DIV,
        rem_reg < size_eff, "divider remainder reached the detent size")
    `BEG_ASSERT_IMPL(a_sub_reduced, aclk, aresetn, state_reg == ST_BTN,
        sub_mag < {27'd0, size_eff}, "sub-detent remainder not reduced before scan")
    `BEG_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready,
        state_reg == ST_DELTA && !s_ready, "poll transfer did not start the sequencer")
    `BEG_ASSERT_NEXT(a_out_blocked, aclk, aresetn,
        state_reg == ST_OUT && m_valid_reg && !m_ready,
        state_reg == ST_OUT && $stable(out_reg), "result loaded over a waiting transfer")

endmodule

// ----- sim/tb_button_encoder_event_generator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_button_encoder_event_generator_top
// Self-checking bench for the button and encoder event generator. A
// scoreboard keeps its own copy of the debounce, press/hold and detent state,
// predicts one event code per accepted poll and checks each event transfer
// in order. Directed polls come first, then random button and encoder
// traffic under several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------

import btn_enc_pkg::*;

class event_scoreboard;
    logic [15:0]            debounce_time;
    logic [15:0]            hold_ms;
    logic [4:0]             detent_size;
    logic [2:0]             on_down_mask;
    logic [NUM_BUTTONS-1:0] last_level;
    logic [NUM_BUTTONS-1:0] armed;
    logic [NUM_BUTTONS-1:0] stable_pressed;
    logic [NUM_BUTTONS-1:0] hold_done;
    logic [31:0]            change_time [NUM_BUTTONS];
    logic [31:0]            down_time [NUM_BUTTONS];
    logic [31:0]            prev_count;
    logic [31:0]            sub_detent;
    int                     pending_detents;
    logic [3:0]             expected_events [$];
    int                     event_tally [16];

    function new();
        debounce_time   = DEBOUNCE_RST;
        hold_ms         = HOLD_RST;
        detent_size     = CPD_RST;
        on_down_mask    = MASK_RST;
        last_level      = '1;
        armed           = '0;
        stable_pressed  = '0;
        hold_done       = '0;
        prev_count      = '0;
        sub_detent      = '0;
        pending_detents = 0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            change_time[i] = '0;
            down_time[i]   = '0;
        end
        for (int i = 0; i < 16; i++) event_tally[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DEBOUNCE:      debounce_time = data;
            REG_HOLD_MS:       hold_ms       = data;
            REG_COUNTS_PER_DT: detent_size   = data[4:0];
            REG_PRESS_ON_DOWN: on_down_mask  = data[2:0];
            default: ;
        endcase
    endfunction

    function void advance_encoder(logic [31:0] count);
        longint size;
        longint rem_s;
        longint whole;
        longint p;
        size = longint'(detent_size);
        if (size < 1) size = 1;
        if (size > 16) size = 16;
        sub_detent = sub_detent + (count - prev_count);
        prev_count = count;
        rem_s = longint'($signed(sub_detent));
        whole = rem_s / size;
        if (whole != 0) begin
            sub_detent = 32'(rem_s - whole * size);
            p = longint'(pending_detents) + whole;
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            pending_detents = int'(p);
        end
    endfunction

    function logic [3:0] scan_button(int i, logic [31:0] now, logic [LEVEL_W-1:0] levels);
        logic       lvl;
        logic       low;
        logic [3:0] press_code;
        lvl        = levels[i];
        press_code = 4'(EV_PRESS_BASE + 2 * i);
        if (lvl != last_level[i]) begin
            last_level[i]  = lvl;
            change_time[i] = now;
            return EV_NONE;
        end
        if ((now - change_time[i]) < 32'(debounce_time)) return EV_NONE;
        low = ~lvl;
        // ignore a button until it has been seen released once
        if (!armed[i]) begin
            if (!low) armed[i] = 1'b1;
            return EV_NONE;
        end
        if (low && !stable_pressed[i]) begin
            stable_pressed[i] = 1'b1;
            down_time[i]      = now;
            hold_done[i]      = 1'b0;
            if (on_down_mask[i]) begin
                hold_done[i] = 1'b1;
                return press_code;
            end
        end else if (low && !hold_done[i] && (now - down_time[i]) >= 32'(hold_ms)) begin
            hold_done[i] = 1'b1;
            return press_code + 4'd1;
        end else if (!low && stable_pressed[i]) begin
            stable_pressed[i] = 1'b0;
            if (!hold_done[i]) return press_code;
        end
        return EV_NONE;
    endfunction

    function void note_poll(logic [31:0] now, logic [LEVEL_W-1:0] levels, logic [31:0] count);
        logic [3:0] ev;
        ev = EV_NONE;
        advance_encoder(count);
        // first reporting button wins, later ones are left untouched
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (ev == EV_NONE) ev = scan_button(i, now, levels);
        end
        if (ev == EV_NONE) begin
            if (pending_detents > 0) begin
                pending_detents--;
                ev = EV_CW;
            end else if (pending_detents < 0) begin
                pending_detents++;
                ev = EV_CCW;
            end
        end
        expected_events.push_back(ev);
    endfunction

    function bit check_event(logic [3:0] got, output string msg);
        logic [3:0] want;
        msg = "";
        event_tally[got]++;
        if (expected_events.size() == 0) begin
            $sformat(msg, "event code %0d with no poll outstanding", got);
            return 1'b0;
        end
        want = expected_events.pop_front();
        if (got !== want) begin
            $sformat(msg, "event_code got %0d want %0d", got, want);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function int outstanding();
        return expected_events.size();
    endfunction
endclass

module tb_button_encoder_event_generator_top;

    localparam int CYCLE_LIMIT   = 800000;
    localparam int PHASE_POLLS   = 225;
    localparam int STALL_CYCLES  = 600;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [31:0]           s_now_ms;
    logic [LEVEL_W-1:0]    s_button_levels;
    logic signed [31:0]    s_encoder_count;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [3:0]            m_event_code;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    event_scoreboard sb = new();

    int          mismatches    = 0;
    int          cycles        = 0;
    int          polls_sent    = 0;
    int          settings_used = 1;
    int          hold_requests = 0;
    int          holds_granted = 0;
    int          stall_left    = 0;
    bit          quiet         = 1'b0;
    logic [31:0] t_now         = '0;
    logic [31:0] enc_count     = '0;
    logic [2:0]  btn_target    = '1;

    button_encoder_event_generator_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_now_ms        (s_now_ms),
        .s_button_levels (s_button_levels),
        .s_encoder_count (s_encoder_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_code    (m_event_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events outstanding", cycles,
                     sb.outstanding());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // sink side: random back-pressure plus long stalls on request
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (holds_granted < hold_requests) begin
            m_ready       <= 1'b0;
            holds_granted <= holds_granted + 1;
            stall_left    <= STALL_CYCLES;
        end else begin
            m_ready <= quiet || ($urandom_range(0, 99) >= 34);
        end
    end

    always @(posedge aclk) begin
        string msg;
        if (aresetn && m_valid && m_ready) begin
            if (!sb.check_event(m_event_code, msg)) report_mismatch(msg);
        end
    end

    task automatic send_poll(input logic [31:0] t, input logic [LEVEL_W-1:0] lv,
                             input logic [31:0] cnt);
        while (!quiet && $urandom_range(0, 99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_now_ms        <= t;
        s_button_levels <= lv;
        s_encoder_count <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_poll(t, lv, cnt);
        polls_sent++;
    endtask

    // drop valid and wait for every outstanding event
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic cfg_write_one(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic write_config(input logic [15:0] deb, input logic [15:0] hold,
                                input logic [15:0] size, input logic [15:0] mask);
        cfg_write_one(REG_DEBOUNCE, deb);
        cfg_write_one(REG_HOLD_MS, hold);
        cfg_write_one(REG_COUNTS_PER_DT, size);
        cfg_write_one(REG_PRESS_ON_DOWN, mask);
        cfg_valid <= 1'b0;
        settings_used++;
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input int phase);
        int          r;
        logic [2:0]  lv;
        for (int k = 0; k < n; k++) begin
            if (phase == 1 && k == 110) drain();
            if (phase == 3 && k == 20) quiet = 1'b1;
            if (phase == 3 && k == 110) quiet = 1'b0;
            if ((phase == 3 && k == 150) || (phase == 4 && k == 40)) hold_requests++;
            r = $urandom_range(0, 99);
            if (r < 60)      t_now = t_now + $urandom_range(1, 15);
            else if (r < 85) t_now = t_now + $urandom_range(16, 80);
            else if (r < 94) t_now = t_now + $urandom_range(200, 1500);
            else if (r < 98) t_now = t_now + $urandom_range(30000, 140000);
            else             t_now = $urandom;
            // held levels with occasional bounce
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(0, 99) < 8) btn_target[i] = ~btn_target[i];
                lv[i] = ($urandom_range(0, 99) < 6) ? ~btn_target[i] : btn_target[i];
            end
            if ($urandom_range(0, 99) < 10) lv = 3'($urandom_range(0, 7));
            r = $urandom_range(0, 99);
            if (r < 55)      enc_count = enc_count + $urandom_range(0, 16) - 32'd8;
            else if (r < 80) enc_count = enc_count;
            else if (r < 96) enc_count = enc_count + $urandom_range(0, 4000) - 32'd2000;
            else             enc_count = $urandom;
            send_poll(t_now, lv, enc_count);
        end
    endtask

    initial begin
        int presses;
        int holds;
        presses = 0;
        holds   = 0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_now_ms        <= '0;
        s_button_levels <= '1;
        s_encoder_count <= '0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_DEBOUNCE;
        cfg_data        <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed polls at reset settings
        send_poll(32'd0,    3'b111, 32'd0);
        send_poll(32'd40,   3'b111, 32'd0);          // arm all buttons
        send_poll(32'd41,   3'b110, 32'd0);
        send_poll(32'd80,   3'b110, 32'd0);          // button 0 down
        send_poll(32'd900,  3'b110, 32'd0);          // button 0 hold
        send_poll(32'd950,  3'b111, 32'd0);
        send_poll(32'd990,  3'b111, 32'd0);          // release after hold: silent
        send_poll(32'd1000, 3'b101, 32'd0);
        send_poll(32'd1040, 3'b101, 32'd0);          // masked button presses on down
        send_poll(32'd1100, 3'b111, 32'd0);
        send_poll(32'd1140, 3'b111, 32'd9);          // two detents clockwise
        send_poll(32'd1141, 3'b111, 32'd9);
        send_poll(32'd1200, 3'b010, 32'd1);          // buttons 0 and 2 together
        send_poll(32'd1240, 3'b010, 32'd1);
        send_poll(32'd1300, 3'b111, 32'd1);
        send_poll(32'd1340, 3'b111, 32'd1);          // button 0 wins, 2 waits
        send_poll(32'd1341, 3'b111, 32'd1);
        send_poll(32'd1342, 3'b111, 32'h7FFF_FFFF);  // pending saturates high
        send_poll(32'd1343, 3'b111, 32'h8000_0000);
        send_poll(32'hFFFF_FFF0, 3'b011, 32'hFFFF_FFFF);
        send_poll(32'h0000_0020, 3'b011, 32'h8000_0001);  // time wraps
        send_poll(32'h0000_0400, 3'b000, 32'h0000_0000);
        t_now     = 32'h0000_0400;
        enc_count = 32'h0000_0000;
        drain();

        write_config(16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(PHASE_POLLS, 1);
        drain();
        write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(PHASE_POLLS, 2);
        drain();
        write_config(16'($urandom_range(5, 40)), 16'($urandom_range(50, 400)),
                     16'($urandom_range(1, 16)), 16'($urandom_range(0, 7)));
        run_phase(PHASE_POLLS, 3);
        drain();
        write_config(16'($urandom_range(0, 60)), 16'($urandom_range(0, 1000)),
                     16'h0011, 16'($urandom) | 16'hFFF8);
        run_phase(PHASE_POLLS, 4);
        drain();
        repeat (100) @(posedge aclk);

        for (int i = 0; i < NUM_BUTTONS; i++) begin
            presses += sb.event_tally[EV_PRESS_BASE + 2 * i];
            holds   += sb.event_tally[EV_PRESS_BASE + 2 * i + 1];
        end
        $display("Ran %0d polls under %0d register settings, incl. a long sink stall.",
                 polls_sent, settings_used);
        $display("Events: none %0d, cw %0d, ccw %0d, press %0d, hold %0d; mismatches %0d",
                 sb.event_tally[EV_NONE], sb.event_tally[EV_CW], sb.event_tally[EV_CCW],
                 presses, holds, mismatches);
        if (mismatches == 0 && sb.outstanding() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
